// ===== hdl/pareto_archive_update_assert.svh =====
`ifndef PARETO_ARCHIVE_UPDATE_ASSERT_SVH
`define PARETO_ARCHIVE_UPDATE_ASSERT_SVH

// Checks that a condition implies another one in the same cycle.
`define PAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define PAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pau_pkg.sv =====
`default_nettype none

package pau_pkg;

	localparam int FIELD_W   = 32;
	localparam int TAG_W     = 16;
	localparam int CNT_W     = 6;
	localparam int DEF_DEPTH = 32;
	localparam int DEF_OBJ_W = 32;

	typedef struct packed {
		logic capture;
		logic shift;
		logic append;
		logic rotate;
		logic wrap;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/pareto_archive_update.sv =====
// Three-objective Pareto archive, smaller is better on every objective.
// Input channel: in_valid/in_ready with obj_a, obj_b, obj_c, item_tag, flush.
// Output channel: out_valid/out_ready with kind, accepted, overflow,
// removed_count, archive_count, entry_tag, entry_a/b/c and last.
// Each input item produces one status item, followed by one dump item per
// archive entry when flush is set and the archive is not empty.
// The score is compared against every cell in the cycle the item is taken.
// Each removed entry then costs one collapsing step of the cell row, and the
// status item follows once no hole is left; removed_count counts the steps.
// A new item is taken only once the previous item's status item and any
// dump it requested have been issued.
// Dump items leave one per cycle if not stalled, rotating the row at cell 0.
// The output register holds a result while the receiver stalls, and the
// block waits at the status or dump step until the register is free.
// Reset empties the archive and drops any result in the output register.
`default_nettype none

`include "pareto_archive_update_assert.svh"

module pareto_archive_update #(
	parameter int ARCHIVE_DEPTH = pau_pkg::DEF_DEPTH,
	parameter int OBJ_WIDTH     = pau_pkg::DEF_OBJ_W
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [pau_pkg::FIELD_W-1:0] obj_a,
	input  wire logic signed [pau_pkg::FIELD_W-1:0] obj_b,
	input  wire logic signed [pau_pkg::FIELD_W-1:0] obj_c,
	input  wire logic [pau_pkg::TAG_W-1:0]          item_tag,
	input  wire logic                               flush,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    kind,
	output logic                                    accepted,
	output logic                                    overflow,
	output logic [pau_pkg::CNT_W-1:0]               removed_count,
	output logic [pau_pkg::CNT_W-1:0]               archive_count,
	output logic [pau_pkg::TAG_W-1:0]               entry_tag,
	output logic signed [pau_pkg::FIELD_W-1:0]      entry_a,
	output logic signed [pau_pkg::FIELD_W-1:0]      entry_b,
	output logic signed [pau_pkg::FIELD_W-1:0]      entry_c,
	output logic                                    last
);

	localparam int TW = pau_pkg::TAG_W;
	localparam int FW = pau_pkg::FIELD_W;
	localparam int NW = pau_pkg::CNT_W;
	localparam int EW = 3 * OBJ_WIDTH + TW;
	localparam int CW = $clog2(ARCHIVE_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PACK = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q, removed_q, dump_idx_q, new_cnt;
	logic          qual_q, flush_q;
	logic [EW-1:0] score_q, in_bus, score_bus;

	logic          out_valid_q, kind_q, accepted_q, overflow_q, last_q;
	logic [NW-1:0] removed_out_q, count_out_q;
	logic [TW-1:0] tag_out_q;
	logic [FW-1:0] a_out_q, b_out_q, c_out_q;

	logic [EW-1:0] ent [ARCHIVE_DEPTH];
	logic [ARCHIVE_DEPTH-1:0] hole, wdom, sdom, seen;
	pau_pkg::cell_ctl_t ctl [ARCHIVE_DEPTH];

	logic in_fire, out_free, any_hole, do_shift, pack_done, do_append, do_rotate;
	logic dump_last;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign any_hole  = |hole;
	assign do_shift  = (state_q == S_PACK) && any_hole;
	assign pack_done = (state_q == S_PACK) && !any_hole && out_free;
	assign do_append = pack_done && qual_q && (count_q < CW'(ARCHIVE_DEPTH));
	assign do_rotate = (state_q == S_DUMP) && out_free;
	assign new_cnt   = count_q + CW'(do_append);
	assign dump_last = (dump_idx_q == count_q - CW'(1));

	assign in_bus = {OBJ_WIDTH'($unsigned(obj_a)), OBJ_WIDTH'($unsigned(obj_b)),
		OBJ_WIDTH'($unsigned(obj_c)), item_tag};
	assign score_bus = (state_q == S_IDLE) ? in_bus : score_q;

	for (genvar i = 0; i < ARCHIVE_DEPTH; i++) begin : g_cell
		logic [EW-1:0] next_entry;
		logic          hole_next, seen_in;

		if (i < ARCHIVE_DEPTH - 1) begin : g_mid
			assign next_entry = ent[i+1];
			assign hole_next  = hole[i+1];
		end else begin : g_end
			assign next_entry = ent[i];
			assign hole_next  = 1'b0;
		end

		if (i == 0) begin : g_first
			assign seen_in = 1'b0;
		end else begin : g_rest
			assign seen_in = seen[i-1];
		end

		assign ctl[i].capture = in_fire;
		assign ctl[i].shift   = do_shift;
		assign ctl[i].append  = do_append && (count_q == CW'(i));
		assign ctl[i].rotate  = do_rotate;
		assign ctl[i].wrap    = (count_q == CW'(i + 1));

		pau_cell #(
			.OBJ_WIDTH(OBJ_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.occupied  (CW'(i) < count_q),
			.score     (score_bus),
			.next_entry(next_entry),
			.head_entry(ent[0]),
			.hole_next (hole_next),
			.seen_in   (seen_in),
			.seen_out  (seen[i]),
			.hole      (hole[i]),
			.wdom      (wdom[i]),
			.sdom      (sdom[i]),
			.entry     (ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			removed_q  <= '0;
			dump_idx_q <= '0;
			qual_q     <= 1'b0;
			flush_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						qual_q    <= !(|wdom);
						flush_q   <= flush;
						removed_q <= '0;
						state_q   <= S_PACK;
					end
				end
				S_PACK: begin
					if (do_shift) begin
						count_q   <= count_q - CW'(1);
						removed_q <= removed_q + CW'(1);
					end else if (out_free) begin
						count_q    <= new_cnt;
						dump_idx_q <= '0;
						state_q    <= (flush_q && new_cnt != '0) ? S_DUMP : S_IDLE;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						dump_idx_q <= dump_idx_q + CW'(1);
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			score_q <= in_bus;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pack_done || do_rotate) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pack_done) begin
			kind_q        <= 1'b0;
			accepted_q    <= do_append;
			overflow_q    <= qual_q && !do_append;
			removed_out_q <= NW'(removed_q);
			count_out_q   <= NW'(new_cnt);
			tag_out_q     <= '0;
			a_out_q       <= '0;
			b_out_q       <= '0;
			c_out_q       <= '0;
			last_q        <= !(flush_q && new_cnt != '0);
		end else if (do_rotate) begin
			kind_q        <= 1'b1;
			accepted_q    <= 1'b0;
			overflow_q    <= 1'b0;
			removed_out_q <= '0;
			count_out_q   <= NW'(count_q);
			tag_out_q     <= ent[0][TW-1:0];
			a_out_q       <= FW'(ent[0][EW-1 -: OBJ_WIDTH]);
			b_out_q       <= FW'(ent[0][TW+2*OBJ_WIDTH-1 -: OBJ_WIDTH]);
			c_out_q       <= FW'(ent[0][TW+OBJ_WIDTH-1 -: OBJ_WIDTH]);
			last_q        <= dump_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign accepted      = accepted_q;
	assign overflow      = overflow_q;
	assign removed_count = removed_out_q;
	assign archive_count = count_out_q;
	assign entry_tag     = tag_out_q;
	assign entry_a       = $signed(a_out_q);
	assign entry_b       = $signed(b_out_q);
	assign entry_c       = $signed(c_out_q);
	assign last          = last_q;

	`PAU_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(ARCHIVE_DEPTH),
		"archive count exceeds depth")
	`PAU_ASSERT_NEXT(a_shift_count, do_shift, count_q == $past(count_q) - CW'(1),
		"collapse step did not drop one entry")
	`PAU_ASSERT_NOW(a_status_packed, pack_done, !any_hole,
		"status issued with holes left in the row")
	`PAU_ASSERT_NOW(a_dump_nonempty, state_q == S_DUMP, count_q != '0,
		"dump of an empty archive")
	`PAU_ASSERT_NOW(a_dom_exclusive, in_fire, !(|(wdom & sdom)),
		"an entry both dominates and is dominated by the score")

endmodule

`default_nettype wire

// ===== hdl/pau_cell.sv =====
`default_nettype none

module pau_cell #(
	parameter int OBJ_WIDTH = pau_pkg::DEF_OBJ_W,
	localparam int EW = 3 * OBJ_WIDTH + pau_pkg::TAG_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pau_pkg::cell_ctl_t ctl,
	input  wire logic               occupied,
	input  wire logic [EW-1:0]      score,
	input  wire logic [EW-1:0]      next_entry,
	input  wire logic [EW-1:0]      head_entry,
	input  wire logic               hole_next,
	input  wire logic               seen_in,
	output logic                    seen_out,
	output logic                    hole,
	output logic                    wdom,
	output logic                    sdom,
	output logic [EW-1:0]           entry
);

	localparam int TW = pau_pkg::TAG_W;

	logic [EW-1:0] entry_q;
	logic          hole_q;
	logic signed [OBJ_WIDTH-1:0] ea, eb, ec, sa, sb, sc;
	logic le, ge, eq, shift_here;

	assign ea = $signed(entry_q[EW-1 -: OBJ_WIDTH]);
	assign eb = $signed(entry_q[TW+2*OBJ_WIDTH-1 -: OBJ_WIDTH]);
	assign ec = $signed(entry_q[TW+OBJ_WIDTH-1 -: OBJ_WIDTH]);
	assign sa = $signed(score[EW-1 -: OBJ_WIDTH]);
	assign sb = $signed(score[TW+2*OBJ_WIDTH-1 -: OBJ_WIDTH]);
	assign sc = $signed(score[TW+OBJ_WIDTH-1 -: OBJ_WIDTH]);

	assign eq = (ea == sa) && (eb == sb) && (ec == sc);
	assign le = (ea <= sa) && (eb <= sb) && (ec <= sc);
	assign ge = (ea >= sa) && (eb >= sb) && (ec >= sc);

	assign wdom = occupied && le && !eq;
	assign sdom = occupied && ge && !eq;

	// A cell moves down once any hole sits at or below it.
	assign shift_here = seen_in || hole_q;
	assign seen_out   = shift_here;
	assign hole       = hole_q;
	assign entry      = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q <= 1'b0;
		end else if (ctl.capture) begin
			hole_q <= sdom;
		end else if (ctl.shift && shift_here) begin
			hole_q <= hole_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift && shift_here) begin
			entry_q <= next_entry;
		end else if (ctl.append) begin
			entry_q <= score;
		end else if (ctl.rotate) begin
			entry_q <= ctl.wrap ? head_entry : next_entry;
		end
	end

endmodule

`default_nettype wire
